>>> rtl/pdls_pkg.sv
package pdls_pkg;

  // Width of every configuration register and of the drive field on the result channel.
  localparam int CFG_W = 16;

  // Probe reading codes.
  localparam logic [1:0] READ_NONE = 2'd0;
  localparam logic [1:0] READ_LOW  = 2'd1;
  localparam logic [1:0] READ_MID  = 2'd2;
  localparam logic [1:0] READ_HIGH = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_TARGET = 2'd0;
  localparam logic [1:0] REG_SPREAD = 2'd1;
  localparam logic [1:0] REG_STEP   = 2'd2;
  localparam logic [1:0] REG_DELAY  = 2'd3;

  // Sequencer modes, encoded as they appear on the result channel.
  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_SETTLE   = 3'd1,
    MODE_LOW      = 3'd2,
    MODE_LOWRAMP  = 3'd3,
    MODE_MID      = 3'd4,
    MODE_HIGHRAMP = 3'd5,
    MODE_HIGH     = 3'd6
  } mode_t;

  // Register file as seen by the step logic.
  typedef struct packed {
    logic [CFG_W-1:0] target_level;
    logic [CFG_W-1:0] level_spread;
    logic [CFG_W-1:0] ramp_step;
    logic [CFG_W-1:0] settle_delay;
  } cfg_t;

endpackage

>>> rtl/pdls_step.sv
module pdls_step
  import pdls_pkg::*;
#(
  parameter int LEVEL_WIDTH = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  cfg_t                   cfg,
  input  mode_t                  mode_i,
  input  logic [COUNT_WIDTH-1:0] count_i,
  input  logic [LEVEL_WIDTH-1:0] drive_i,
  input  logic [1:0]             reading_i,
  output mode_t                  mode_o,
  output logic [COUNT_WIDTH-1:0] count_o,
  output logic [LEVEL_WIDTH-1:0] drive_o
);

  localparam int LW = LEVEL_WIDTH;
  localparam int NW = COUNT_WIDTH;
  // Wide enough to compare the incremented count with the delay register exactly.
  localparam int XW = ((NW > CFG_W) ? NW : CFG_W) + 1;

  logic [LW-1:0] tgt;
  logic [LW-1:0] spr;
  logic [LW-1:0] stp;
  logic [LW-1:0] lo_lvl;
  logic [LW-1:0] hi_lvl;
  logic [LW:0]   hi_sum;
  logic [LW:0]   lo_plus;
  logic [LW:0]   tgt_plus;
  logic [LW:0]   d_plus;
  logic [LW-1:0] d_minus;
  logic          below_lo;
  logic          above_tgt;
  logic          below_tgt;
  logic          above_hi;
  logic [NW:0]   cnt_inc;
  logic          settle_done;

  // Effective register values at the level width.
  assign tgt = LW'(cfg.target_level);
  assign spr = LW'(cfg.level_spread);
  assign stp = LW'(cfg.ramp_step);

  // Low and high levels, saturated at zero and at the level maximum.
  assign lo_lvl = (spr >= tgt) ? '0 : (tgt - spr);
  assign hi_sum = {1'b0, tgt} + {1'b0, spr};
  assign hi_lvl = hi_sum[LW] ? '1 : hi_sum[LW-1:0];

  // Ramp sums carry one extra bit so that the end-level compares never wrap.
  assign lo_plus  = {1'b0, lo_lvl} + {1'b0, stp};
  assign tgt_plus = {1'b0, tgt} + {1'b0, stp};
  assign d_plus   = {1'b0, drive_i} + {1'b0, stp};
  assign d_minus  = drive_i - stp;

  assign below_lo  = {1'b0, drive_i} < lo_plus;
  assign above_tgt = d_plus > {1'b0, tgt};
  assign below_tgt = {1'b0, drive_i} < tgt_plus;
  assign above_hi  = d_plus > {1'b0, hi_lvl};

  // Settling count: exact increment for the compare, saturated for storage.
  assign cnt_inc     = {1'b0, count_i} + {{NW{1'b0}}, 1'b1};
  assign settle_done = XW'(cnt_inc) > XW'(cfg.settle_delay);

  // Next mode.
  always_comb begin
    mode_o = mode_i;
    if (reading_i == READ_NONE) begin
      mode_o = MODE_IDLE;
    end else begin
      unique case (mode_i)
        MODE_SETTLE: begin
          mode_o = settle_done ? MODE_LOW : MODE_SETTLE;
        end
        MODE_LOW: begin
          if (reading_i == READ_MID) begin
            mode_o = MODE_LOWRAMP;
          end else if (reading_i == READ_HIGH) begin
            mode_o = MODE_MID;
          end
        end
        MODE_LOWRAMP: begin
          if (reading_i == READ_LOW) begin
            mode_o = below_lo ? MODE_LOW : MODE_LOWRAMP;
          end else if (reading_i == READ_MID) begin
            mode_o = above_tgt ? MODE_MID : MODE_LOWRAMP;
          end else begin
            mode_o = MODE_HIGHRAMP;
          end
        end
        MODE_MID: begin
          if (reading_i == READ_LOW) begin
            mode_o = MODE_LOWRAMP;
          end else if (reading_i == READ_HIGH) begin
            mode_o = MODE_HIGHRAMP;
          end
        end
        MODE_HIGHRAMP: begin
          if (reading_i == READ_LOW) begin
            mode_o = MODE_LOW;
          end else if (reading_i == READ_MID) begin
            mode_o = below_tgt ? MODE_MID : MODE_HIGHRAMP;
          end else begin
            mode_o = above_hi ? MODE_HIGH : MODE_HIGHRAMP;
          end
        end
        MODE_HIGH: begin
          if (reading_i == READ_LOW) begin
            mode_o = MODE_LOWRAMP;
          end else if (reading_i == READ_MID) begin
            mode_o = MODE_HIGHRAMP;
          end
        end
        default: begin
          // Idle, or any code that does not name a mode, starts settling.
          mode_o = MODE_SETTLE;
        end
      endcase
    end
  end

  // Drive value and settling count.
  always_comb begin
    drive_o = drive_i;
    count_o = count_i;
    if (reading_i == READ_NONE) begin
      drive_o = '0;
    end else begin
      unique case (mode_i)
        MODE_SETTLE: begin
          count_o = cnt_inc[NW] ? '1 : cnt_inc[NW-1:0];
        end
        MODE_LOW: begin
          drive_o = lo_lvl;
        end
        MODE_LOWRAMP: begin
          if (reading_i == READ_LOW) begin
            drive_o = below_lo ? lo_lvl : d_minus;
          end else if (reading_i == READ_MID) begin
            drive_o = above_tgt ? tgt : d_plus[LW-1:0];
          end
        end
        MODE_MID: begin
          drive_o = tgt;
        end
        MODE_HIGHRAMP: begin
          if (reading_i == READ_MID) begin
            drive_o = below_tgt ? tgt : d_minus;
          end else if (reading_i == READ_HIGH) begin
            drive_o = above_hi ? hi_lvl : d_plus[LW-1:0];
          end
        end
        MODE_HIGH: begin
          drive_o = hi_lvl;
        end
        default: begin
          // Entering settling clears both the count and the drive.
          drive_o = '0;
          count_o = '0;
        end
      endcase
    end
  end

endmodule

>>> rtl/probe_driven_level_sequencer.sv
// Channel   Direction  Handshake               Payload
// in_       slave      in_tvalid / in_tready   in_tdata:  probe_reading
// out_      master     out_tvalid / out_tready out_tdata: drive_level, mode_code
// cfg_      slave      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each accepted sample produces one result transaction, registered in the cycle after it is accepted.
// The mode, count and drive registers double as the result register, so a new
// sample is taken in the same cycle as the previous result is taken: one sample a cycle.
// A stalled result holds the input channel off until out_tready returns.
// Synchronous active-low reset puts the block in idle with drive zero and loads
// the register defaults; the configuration port is always ready.
module probe_driven_level_sequencer
  import pdls_pkg::*;
#(
  parameter int LEVEL_WIDTH = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [1:0] probe_reading, [7:2] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] drive_level, [18:16] mode_code, [23:19] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t                   cfg_r;
  mode_t                  mode_r;
  mode_t                  mode_nxt;
  logic [COUNT_WIDTH-1:0] count_r;
  logic [COUNT_WIDTH-1:0] count_nxt;
  logic [LEVEL_WIDTH-1:0] drive_r;
  logic [LEVEL_WIDTH-1:0] drive_nxt;
  logic                   out_valid_r;
  logic                   in_fire;

  // Configuration writes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_level <= '0;
      cfg_r.level_spread <= '0;
      cfg_r.ramp_step    <= CFG_W'(1);
      cfg_r.settle_delay <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TARGET: cfg_r.target_level <= cfg_data;
        REG_SPREAD: cfg_r.level_spread <= cfg_data;
        REG_STEP:   cfg_r.ramp_step    <= cfg_data;
        REG_DELAY:  cfg_r.settle_delay <= cfg_data;
      endcase
    end
  end

  // A sample is taken when the result slot is empty or is being emptied.
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  pdls_step #(
    .LEVEL_WIDTH (LEVEL_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .cfg       (cfg_r),
    .mode_i    (mode_r),
    .count_i   (count_r),
    .drive_i   (drive_r),
    .reading_i (in_tdata[1:0]),
    .mode_o    (mode_nxt),
    .count_o   (count_nxt),
    .drive_o   (drive_nxt)
  );

  // Sequencer state, which is also the result payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      count_r <= '0;
      drive_r <= '0;
    end else if (in_fire) begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
      drive_r <= drive_nxt;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, mode_r, CFG_W'(drive_r)};

`ifndef SYNTHESIS
  // A zero reading always lands in idle with the drive at zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_tdata[1:0] == READ_NONE)
    |=> out_valid_r && (mode_r == MODE_IDLE) && (drive_r == '0))
    else $error("zero reading did not return to idle with zero drive");

  // Idle and settling never carry a drive.
  assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IDLE) || (mode_r == MODE_SETTLE) |-> (drive_r == '0))
    else $error("drive nonzero in idle or settling");

  // Leaving idle enters settling with a cleared count.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (mode_r == MODE_IDLE) && (in_tdata[1:0] != READ_NONE)
    |=> (mode_r == MODE_SETTLE) && (count_r == '0))
    else $error("settling entered without clearing the count");

  // The state only moves with an accepted sample.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(mode_r) && $stable(drive_r) && $stable(count_r))
    else $error("state changed without an accepted sample");
`endif

endmodule
